>>> hw/rtl/ted_pkg.sv
`default_nettype none

package ted_pkg;

    // Decoder modes.
    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_ESCAPE = 3'd1;
    localparam logic [2:0] MODE_OCTAL  = 3'd2;
    localparam logic [2:0] MODE_SKIP   = 3'd3;
    localparam logic [2:0] MODE_CARET  = 3'd4;

    // Input characters with a meaning of their own.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_LOWER_E = 8'h65;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_1 = 8'h31;
    localparam logic [4:0] OCTAL_DIGIT_HIGH = 5'b00110;

    // Decoded control codes.
    localparam logic [7:0] CODE_ESC = 8'd27;
    localparam logic [7:0] CODE_LF  = 8'd10;
    localparam logic [7:0] CODE_CR  = 8'd13;
    localparam logic [7:0] CODE_TAB = 8'd9;
    localparam logic [7:0] CODE_BS  = 8'd8;
    localparam logic [7:0] CODE_FF  = 8'd12;

    localparam int MAX_LENGTH_DEFAULT = 1023;
    localparam int LENGTH_WIDTH       = 10;
    localparam int QUEUE_DEPTH        = 4;

    typedef struct packed {
        logic       is_end;
        logic [7:0] data;
    } t_item;

    // A request holds the one or two results of one accepted byte.
    typedef struct packed {
        t_item first;
        logic  two;
        t_item second;
    } t_req;

endpackage

`default_nettype wire

>>> hw/rtl/ted_front.sv
`default_nettype none

module ted_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire logic [7:0]   i_in_byte,
    input  wire logic         i_queue_full,
    output logic              o_push,
    output ted_pkg::t_req     o_req
);

    logic [2:0]     r_mode, n_mode;
    logic [7:0]     r_octal_acc, n_octal_acc;
    logic           r_octal_nonzero, n_octal_nonzero;

    logic           accept;
    logic [7:0]     b;
    logic           nh_emit;
    ted_pkg::t_item nh_item;
    logic [2:0]     nh_mode;
    logic           pre_emit;
    ted_pkg::t_item pre_item;
    logic           m_emit;
    ted_pkg::t_item m_item;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;
    assign b          = i_in_byte;

    // Normal-mode byte handling, also after a rejected prefix, octal run or skip.
    always_comb begin
        nh_emit     = 1'b0;
        nh_item     = '0;
        nh_mode     = ted_pkg::MODE_NORMAL;
        priority if (b == ted_pkg::CH_NUL || b == ted_pkg::CH_LF || b == ted_pkg::CH_COLON) begin
            nh_emit        = 1'b1;
            nh_item.is_end = 1'b1;
        end else if (b == ted_pkg::CH_BSLASH) begin
            nh_mode = ted_pkg::MODE_ESCAPE;
        end else if (b == ted_pkg::CH_CARET) begin
            nh_mode = ted_pkg::MODE_CARET;
        end else begin
            nh_emit      = 1'b1;
            nh_item.data = b;
        end
    end

    always_comb begin
        n_mode          = r_mode;
        n_octal_acc     = r_octal_acc;
        n_octal_nonzero = r_octal_nonzero;
        pre_emit        = 1'b0;
        pre_item        = '0;
        m_emit          = 1'b0;
        m_item          = '0;
        unique case (r_mode)
            ted_pkg::MODE_ESCAPE: begin
                n_mode = ted_pkg::MODE_NORMAL;
                unique case (b)
                    ted_pkg::CH_LF: n_mode = ted_pkg::MODE_SKIP;
                    ted_pkg::CH_UPPER_E, ted_pkg::CH_LOWER_E: begin
                        m_emit      = 1'b1;
                        m_item.data = ted_pkg::CODE_ESC;
                    end
                    ted_pkg::CH_LOWER_N: begin
                        m_emit      = 1'b1;
                        m_item.data = ted_pkg::CODE_LF;
                    end
                    ted_pkg::CH_LOWER_R: begin
                        m_emit      = 1'b1;
                        m_item.data = ted_pkg::CODE_CR;
                    end
                    ted_pkg::CH_LOWER_T: begin
                        m_emit      = 1'b1;
                        m_item.data = ted_pkg::CODE_TAB;
                    end
                    ted_pkg::CH_LOWER_B: begin
                        m_emit      = 1'b1;
                        m_item.data = ted_pkg::CODE_BS;
                    end
                    ted_pkg::CH_LOWER_F: begin
                        m_emit      = 1'b1;
                        m_item.data = ted_pkg::CODE_FF;
                    end
                    ted_pkg::CH_DIGIT_0, ted_pkg::CH_DIGIT_1: begin
                        n_mode          = ted_pkg::MODE_OCTAL;
                        n_octal_acc     = {7'd0, b[0]};
                        n_octal_nonzero = b[0];
                    end
                    default: begin
                        pre_emit      = 1'b1;
                        pre_item.data = ted_pkg::CH_BSLASH;
                        m_emit        = nh_emit;
                        m_item        = nh_item;
                        n_mode        = nh_mode;
                    end
                endcase
            end
            ted_pkg::MODE_OCTAL: begin
                priority if (b[7:3] == ted_pkg::OCTAL_DIGIT_HIGH) begin
                    n_octal_acc     = {r_octal_acc[4:0], b[2:0]};
                    n_octal_nonzero = r_octal_nonzero || (b[2:0] != 3'd0);
                end else if (!r_octal_nonzero) begin
                    // An all-zero run ends the string; the closing byte is dropped.
                    m_emit        = 1'b1;
                    m_item.is_end = 1'b1;
                    n_mode        = ted_pkg::MODE_NORMAL;
                end else begin
                    pre_emit        = 1'b1;
                    pre_item.data   = r_octal_acc;
                    n_octal_acc     = 8'd0;
                    n_octal_nonzero = 1'b0;
                    m_emit          = nh_emit;
                    m_item          = nh_item;
                    n_mode          = nh_mode;
                end
            end
            ted_pkg::MODE_SKIP: begin
                if (b != ted_pkg::CH_SPACE && b != ted_pkg::CH_TAB) begin
                    m_emit = nh_emit;
                    m_item = nh_item;
                    n_mode = nh_mode;
                end
            end
            ted_pkg::MODE_CARET: begin
                if (b >= ted_pkg::CH_UPPER_A && b <= ted_pkg::CH_UPPER_Z) begin
                    m_emit      = 1'b1;
                    m_item.data = b - ted_pkg::CH_AT;
                    n_mode      = ted_pkg::MODE_NORMAL;
                end else begin
                    pre_emit      = 1'b1;
                    pre_item.data = ted_pkg::CH_CARET;
                    m_emit        = nh_emit;
                    m_item        = nh_item;
                    n_mode        = nh_mode;
                end
            end
            default: begin
                m_emit = nh_emit;
                m_item = nh_item;
                n_mode = nh_mode;
            end
        endcase
        // A terminator returns the decoder to its reset state.
        if (m_emit && m_item.is_end) begin
            n_octal_acc     = 8'd0;
            n_octal_nonzero = 1'b0;
        end
    end

    assign o_push       = accept && (pre_emit || m_emit);
    assign o_req.first  = pre_emit ? pre_item : m_item;
    assign o_req.two    = pre_emit && m_emit;
    assign o_req.second = m_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= ted_pkg::MODE_NORMAL;
            r_octal_acc     <= 8'd0;
            r_octal_nonzero <= 1'b0;
        end else if (accept) begin
            r_mode          <= n_mode;
            r_octal_acc     <= n_octal_acc;
            r_octal_nonzero <= n_octal_nonzero;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ted_queue.sv
`default_nettype none

module ted_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ted_pkg::t_req i_req,
    output logic               o_full,
    output logic               o_valid,
    output ted_pkg::t_req      o_req,
    input  wire logic          i_pop
);

    localparam int Depth = ted_pkg::QUEUE_DEPTH;
    localparam int PtrW  = $clog2(Depth);

    ted_pkg::t_req     r_mem [Depth];
    logic [PtrW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [PtrW:0]     r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == (PtrW+1)'(Depth));
    assign o_valid = (r_count != '0);
    assign o_req   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ted_back.sv
`default_nettype none

module ted_back #(
    parameter int MAX_LENGTH = ted_pkg::MAX_LENGTH_DEFAULT
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire ted_pkg::t_req i_q_req,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_last,
    output logic [ted_pkg::LENGTH_WIDTH-1:0] o_decoded_length
);

    localparam int CntW = $clog2(MAX_LENGTH + 1);
    localparam int LenW = ted_pkg::LENGTH_WIDTH;

    logic                 r_valid;
    logic [7:0]           r_byte;
    logic                 r_last;
    logic [LenW-1:0]      r_len;
    logic                 r_phase;
    logic [CntW-1:0]      r_count;

    logic                 load;
    ted_pkg::t_item       item;
    logic [CntW+LenW-1:0] count_ext;

    assign load      = i_q_valid && (!r_valid || i_out_ready);
    assign item      = r_phase ? i_q_req.second : i_q_req.first;
    assign o_q_pop   = load && (r_phase || !i_q_req.two);
    assign count_ext = {{LenW{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
            r_count <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= !r_phase && i_q_req.two;
                if (item.is_end) begin
                    r_count <= '0;
                end else if (r_count < CntW'(MAX_LENGTH)) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= item.data;
            r_last <= item.is_end;
            r_len  <= item.is_end ? count_ext[LenW-1:0] : '0;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_out_byte       = r_byte;
    assign o_last           = r_last;
    assign o_decoded_length = r_len;

endmodule

`default_nettype wire

>>> hw/rtl/termcap_escape_decoder.sv
`default_nettype none

// Streaming unescaper for termcap string values. Raw bytes enter on the
// input channel one per request and decoded bytes leave on the output
// channel in the same order. Backslash escapes (E, e, n, r, t, b, f), octal
// runs opened by a backslash and 0 or 1, backslash-newline with blank
// skipping, and caret control codes are translated; a prefix that does not
// form a valid escape is passed through literally. A NUL, newline or colon,
// or an octal run whose digits are all zero, ends the string with a result
// that has o_last set, o_out_byte zero and o_decoded_length holding the
// number of bytes emitted before it, saturated at MAX_LENGTH and shown in
// its low ten bits; o_decoded_length is zero on every other result. The
// block takes one input byte per cycle while the queue has room and
// delivers one result per cycle while the output is ready. A byte that
// yields two results (a rejected escape or caret followed by another
// byte, or an octal run closed by a data byte) sends them out one after
// the other; the input side keeps accepting until the four-entry request
// queue between the decoder and the output stage is full. A byte that
// yields nothing, such as the backslash itself, produces no result.
// The front stage holds the escape mode and the octal accumulator and
// turns each byte into a request of one or two results. The back stage
// drains the queue, splits double requests, counts emitted data bytes
// and drives the output register.

module termcap_escape_decoder #(
    parameter int MAX_LENGTH = ted_pkg::MAX_LENGTH_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_last,
    output logic [ted_pkg::LENGTH_WIDTH-1:0] o_decoded_length
);

    logic          push;
    ted_pkg::t_req push_req;
    logic          queue_full;
    logic          queue_valid;
    ted_pkg::t_req queue_req;
    logic          queue_pop;

    // Decode stage: classifies each byte against the current escape mode.
    ted_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_req        (push_req)
    );

    // Short queue so the decoder keeps running while output is stalled.
    ted_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (push_req),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_req   (queue_req),
        .i_pop   (queue_pop)
    );

    // Output stage: one result per cycle while the output is ready, string length bookkeeping.
    ted_back #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (queue_valid),
        .i_q_req          (queue_req),
        .o_q_pop          (queue_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_last           (o_last),
        .o_decoded_length (o_decoded_length)
    );

endmodule

`default_nettype wire
